### rtl/core/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types and constants for the SRPT preemptive scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int TIME_BITS       = 48;
  localparam int ID_BITS         = 16;
  localparam int QUEUE_DEPTH_DEF = 64;

  typedef logic [TIME_BITS-1:0] sps_time_t;
  typedef logic [ID_BITS-1:0]   sps_id_t;

  // Event codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_DONE   = 1'b1;

  typedef struct packed {
    logic      func;
    sps_id_t   job_id;
    sps_time_t job_size;
    sps_time_t current_time;
  } sps_in_t;

  typedef struct packed {
    logic      done_valid;
    sps_id_t   done_id;
    logic      cancel_completion;
    logic      schedule_valid;
    sps_time_t schedule_time;
    logic      queue_full;
  } sps_out_t;

  // One waiting-queue entry
  typedef struct packed {
    sps_id_t   id;
    sps_time_t rem;
  } sps_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR_A,
    ST_ARR_B,
    ST_CMP,
    ST_SCAN,
    ST_SCAN_END,
    ST_POP,
    ST_MOVE
  } sps_state_t;

endpackage

`default_nettype wire

### rtl/core/sps_queue_mem.sv
// ----------------------------------------------------------------------------
// sps_queue_mem
// Waiting-queue storage: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_queue_mem #(
  parameter int DEPTH = sps_pkg::QUEUE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire sps_pkg::sps_entry_t wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output sps_pkg::sps_entry_t      rdata
);
  import sps_pkg::*;

  sps_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/srpt_preemptive_scheduler_top.sv
// ----------------------------------------------------------------------------
// srpt_preemptive_scheduler_top
// Preemptive shortest-remaining-time scheduler with a memory-held queue.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word on in_word and raise start; it is taken on a clock edge
//   where busy is low. Each word gives exactly one result word, shown on
//   out_word for one cycle with out_valid high; the receiver cannot stall.
//   Arrivals pass through ARR_A (elapsed time) and ARR_B (remaining time,
//   compare and queue write) before the result strobe; the next word can be
//   taken once the block is back in idle.
//   Completions with an empty queue strobe straight after the CMP state;
//   otherwise the waiting entries are kept unsorted in a single-port-read RAM
//   and the minimum (remaining time, then lower id) is found by one read per
//   cycle, so the strobe comes after the scan, the read of the last entry and
//   the move (states SCAN, SCAN_END, POP, MOVE). The popped slot is refilled
//   with the last entry. The RAM read port sets the length of the scan.
//   Reset (rst_n low, synchronous) empties the queue and stops the running
//   job; RAM contents need no clearing since only slots below the count
//   are read.
// ----------------------------------------------------------------------------
`default_nettype none

module srpt_preemptive_scheduler_top #(
  parameter int QUEUE_DEPTH = sps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sps_pkg::sps_in_t in_word,
  output logic                  out_valid,
  output sps_pkg::sps_out_t     out_word
);
  import sps_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  sps_state_t state_r, state_nxt;
  sps_in_t    in_r;
  logic       run_valid_r;
  sps_id_t    run_id_r;
  sps_time_t  run_rem_r;
  sps_time_t  run_start_r;
  logic [CW-1:0] cnt_r;
  sps_time_t  elapsed_r;
  logic [AW-1:0] scan_r;
  logic [AW-1:0] rd_addr_r;
  logic       rv_r;
  logic       first_r;
  sps_entry_t best_r;
  logic [AW-1:0] best_idx_r;
  logic       out_valid_r;
  sps_out_t   out_r;

  // RAM port signals
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  sps_entry_t    mem_wdata, mem_rdata;

  logic          accept;
  logic [CW-1:0] cnt_m1;
  logic          q_full;
  sps_time_t     cur_rem;
  logic          preempt;
  logic          arr_start;
  logic          rd_better;

  assign accept = start && !busy;
  assign cnt_m1 = cnt_r - 1'b1;
  assign q_full = (cnt_r == CW'(QUEUE_DEPTH));

  // Remaining time of the running job, saturating at zero
  assign cur_rem = (run_rem_r > elapsed_r) ? (run_rem_r - elapsed_r) : '0;
  assign preempt = cur_rem > in_r.job_size;

  // New arrival becomes the running job
  assign arr_start = !run_valid_r || (!q_full && preempt);

  assign rd_better = (mem_rdata.rem < best_r.rem) ||
                     ((mem_rdata.rem == best_r.rem) && (mem_rdata.id < best_r.id));

  sps_queue_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_word.func == FUNC_ARRIVE) ? ST_ARR_A : ST_CMP;
        end
      end
      ST_ARR_A:    state_nxt = ST_ARR_B;
      ST_ARR_B:    state_nxt = ST_IDLE;
      ST_CMP:      state_nxt = (cnt_r == '0) ? ST_IDLE : ST_SCAN;
      ST_SCAN: begin
        if (scan_r == cnt_m1[AW-1:0]) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_POP;
      ST_POP:      state_nxt = ST_MOVE;
      ST_MOVE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    busy      = (state_r != ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = preempt ? sps_entry_t'{id: run_id_r, rem: cur_rem}
                        : sps_entry_t'{id: in_r.job_id, rem: in_r.job_size};
    mem_re    = 1'b0;
    mem_raddr = scan_r;
    unique case (state_r)
      ST_ARR_B: begin
        mem_we = run_valid_r && !q_full;
      end
      ST_SCAN: begin
        mem_re = 1'b1;
      end
      ST_POP: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[AW-1:0];
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx_r;
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      run_valid_r <= 1'b0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= mem_re && (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_ARR_B) || (state_r == ST_MOVE) ||
                     ((state_r == ST_CMP) && (cnt_r == '0));
      unique case (state_r)
        ST_ARR_B: begin
          if (!run_valid_r) begin
            run_valid_r <= 1'b1;
          end else if (!q_full) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_CMP: begin
          if (cnt_r == '0) begin
            run_valid_r <= 1'b0;
          end
        end
        ST_MOVE: begin
          run_valid_r <= 1'b1;
          cnt_r       <= cnt_m1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_word;
    end
    rd_addr_r <= mem_raddr;

    // Running minimum over the scan
    if (rv_r && (first_r || rd_better)) begin
      best_r     <= mem_rdata;
      best_idx_r <= rd_addr_r;
    end
    if (rv_r) begin
      first_r <= 1'b0;
    end

    unique case (state_r)
      ST_ARR_A: begin
        elapsed_r <= (in_r.current_time >= run_start_r) ?
                     (in_r.current_time - run_start_r) : '0;
      end
      ST_ARR_B: begin
        if (arr_start) begin
          run_id_r    <= in_r.job_id;
          run_rem_r   <= in_r.job_size;
          run_start_r <= in_r.current_time;
        end
        out_r <= sps_out_t'{
          done_valid:        1'b0,
          done_id:           sps_id_t'(0),
          cancel_completion: arr_start && run_valid_r,
          schedule_valid:    arr_start,
          schedule_time:     arr_start ? (in_r.current_time + in_r.job_size)
                                       : sps_time_t'(0),
          queue_full:        run_valid_r && q_full
        };
      end
      ST_CMP: begin
        scan_r  <= '0;
        first_r <= 1'b1;
        out_r   <= sps_out_t'{
          done_valid:        run_valid_r,
          done_id:           run_valid_r ? run_id_r : sps_id_t'(0),
          cancel_completion: 1'b0,
          schedule_valid:    1'b0,
          schedule_time:     sps_time_t'(0),
          queue_full:        1'b0
        };
      end
      ST_SCAN: begin
        scan_r <= scan_r + 1'b1;
      end
      ST_MOVE: begin
        run_id_r    <= best_r.id;
        run_rem_r   <= best_r.rem;
        run_start_r <= in_r.current_time;
        out_r       <= sps_out_t'{
          done_valid:        out_r.done_valid,
          done_id:           out_r.done_id,
          cancel_completion: 1'b0,
          schedule_valid:    1'b1,
          schedule_time:     in_r.current_time + best_r.rem,
          queue_full:        1'b0
        };
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held two cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting a word");

  a_cancel_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cancel_completion) |-> out_r.schedule_valid)
    else $error("cancel without new schedule");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> (cnt_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### bench/srpt_preemptive_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// srpt_preemptive_scheduler_top_tb
// Self-checking bench for the SRPT scheduler. Arrival and completion words
// (a directed table, a queue fill and drain, then random traffic with mostly
// small job sizes and times) go to the block. A built-in scheduler model
// predicts each result word, and the block's output is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module srpt_preemptive_scheduler_top_tb;
  import sps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH    = QUEUE_DEPTH_DEF;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 850;
  localparam int N_DIRECTED = 21;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sps_in_t  in_word;
  logic     out_valid;
  sps_out_t out_word;

  srpt_preemptive_scheduler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Scheduler model state
  logic      m_run_valid;
  sps_id_t   m_run_id;
  sps_time_t m_run_rem;
  sps_time_t m_run_start;
  sps_id_t   m_wait_id  [QDEPTH];
  sps_time_t m_wait_rem [QDEPTH];
  int        m_wait_cnt;

  sps_out_t  pending_results [$];
  int        n_errors;
  int        idle_cycles;

  // Sorted insert; equal keys go behind the ones already queued
  function automatic void wait_queue_insert(input sps_id_t id, input sps_time_t rem);
    int pos;
    pos = 0;
    while (pos < m_wait_cnt && (m_wait_rem[pos] < rem ||
           (m_wait_rem[pos] == rem && m_wait_id[pos] <= id)))
      pos++;
    for (int k = m_wait_cnt; k > pos; k--) begin
      m_wait_id[k]  = m_wait_id[k-1];
      m_wait_rem[k] = m_wait_rem[k-1];
    end
    m_wait_id[pos]  = id;
    m_wait_rem[pos] = rem;
    m_wait_cnt++;
  endfunction

  function automatic sps_out_t schedule_event(input sps_in_t w);
    sps_out_t  r;
    sps_time_t elapsed, rem;
    r = '0;
    if (w.func == FUNC_ARRIVE) begin
      if (!m_run_valid) begin
        m_run_valid = 1'b1;
        m_run_id    = w.job_id;
        m_run_rem   = w.job_size;
        m_run_start = w.current_time;
        r.schedule_valid = 1'b1;
        r.schedule_time  = w.current_time + w.job_size;
      end else if (m_wait_cnt >= QDEPTH) begin
        r.queue_full = 1'b1;
      end else begin
        elapsed = (w.current_time >= m_run_start) ? w.current_time - m_run_start : '0;
        rem = (m_run_rem > elapsed) ? m_run_rem - elapsed : '0;
        if (rem > w.job_size) begin
          wait_queue_insert(m_run_id, rem);
          m_run_id    = w.job_id;
          m_run_rem   = w.job_size;
          m_run_start = w.current_time;
          r.cancel_completion = 1'b1;
          r.schedule_valid    = 1'b1;
          r.schedule_time     = w.current_time + w.job_size;
        end else begin
          wait_queue_insert(w.job_id, w.job_size);
        end
      end
    end else begin
      if (m_run_valid) begin
        r.done_valid = 1'b1;
        r.done_id    = m_run_id;
      end
      if (m_wait_cnt > 0) begin
        m_run_valid = 1'b1;
        m_run_id    = m_wait_id[0];
        m_run_rem   = m_wait_rem[0];
        m_run_start = w.current_time;
        for (int k = 1; k < m_wait_cnt; k++) begin
          m_wait_id[k-1]  = m_wait_id[k];
          m_wait_rem[k-1] = m_wait_rem[k];
        end
        m_wait_cnt--;
        r.schedule_valid = 1'b1;
        r.schedule_time  = w.current_time + m_run_rem;
      end else begin
        m_run_valid = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  // Result checker
  always @(posedge clk) begin
    sps_out_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_word, 0);
      end else begin
        e = pending_results.pop_front();
        if (out_word.done_valid !== e.done_valid)
          report_mismatch("done_valid", out_word.done_valid, e.done_valid);
        if (out_word.done_id !== e.done_id)
          report_mismatch("done_id", out_word.done_id, e.done_id);
        if (out_word.cancel_completion !== e.cancel_completion)
          report_mismatch("cancel_completion", out_word.cancel_completion,
                          e.cancel_completion);
        if (out_word.schedule_valid !== e.schedule_valid)
          report_mismatch("schedule_valid", out_word.schedule_valid, e.schedule_valid);
        if (out_word.schedule_time !== e.schedule_time)
          report_mismatch("schedule_time", out_word.schedule_time, e.schedule_time);
        if (out_word.queue_full !== e.queue_full)
          report_mismatch("queue_full", out_word.queue_full, e.queue_full);
      end
    end
  end

  // Watchdog on cycles with no accepted word in either direction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed rows; a known result is given only where it is obvious
  typedef struct {
    sps_in_t  w;
    logic     known;
    sps_out_t r;
  } dir_row_t;

  dir_row_t dir_table [N_DIRECTED];
  localparam sps_time_t TMAX = {TIME_BITS{1'b1}};

  function automatic sps_in_t mk(input logic f, input sps_id_t id,
                                 input sps_time_t sz, input sps_time_t t);
    sps_in_t w;
    w.func = f; w.job_id = id; w.job_size = sz; w.current_time = t;
    return w;
  endfunction

  function automatic sps_out_t res(input logic dv, input sps_id_t di, input logic c,
                                   input logic sv, input sps_time_t st);
    sps_out_t r;
    r = '0;
    r.done_valid = dv; r.done_id = di; r.cancel_completion = c;
    r.schedule_valid = sv; r.schedule_time = st;
    return r;
  endfunction

  initial begin
    // completion with nothing running, after reset
    dir_table[0]  = '{mk(FUNC_DONE, 16'hFFFF, TMAX, TMAX), 1'b1, res(0, 0, 0, 0, 0)};
    // arrival onto idle block, extremes and wrap of schedule time
    dir_table[1]  = '{mk(FUNC_ARRIVE, 16'hFFFF, TMAX, 48'd1), 1'b1, res(0, 0, 0, 1, 0)};
    dir_table[2]  = '{mk(FUNC_DONE, 0, 0, 48'd5), 1'b1, res(1, 16'hFFFF, 0, 0, 0)};
    dir_table[3]  = '{mk(FUNC_ARRIVE, 16'd7, 48'd100, 48'd1000), 1'b1,
                      res(0, 0, 0, 1, 48'd1100)};
    // preemption by a shorter job
    dir_table[4]  = '{mk(FUNC_ARRIVE, 16'd3, 48'd10, 48'd1010), 1'b0, '0};
    // equal remaining time, different ids, no preemption
    dir_table[5]  = '{mk(FUNC_ARRIVE, 16'd9, 48'd90, 48'd1010), 1'b0, '0};
    dir_table[6]  = '{mk(FUNC_ARRIVE, 16'd2, 48'd90, 48'd1010), 1'b0, '0};
    // equal key and equal id
    dir_table[7]  = '{mk(FUNC_ARRIVE, 16'd2, 48'd90, 48'd1010), 1'b0, '0};
    // time earlier than run start
    dir_table[8]  = '{mk(FUNC_ARRIVE, 16'd4, 48'd9, 48'd0), 1'b0, '0};
    // elapsed past remaining: saturates, size zero job
    dir_table[9]  = '{mk(FUNC_ARRIVE, 16'd0, 48'd0, TMAX), 1'b0, '0};
    dir_table[10] = '{mk(FUNC_DONE, 0, 0, 48'd2000), 1'b0, '0};
    dir_table[11] = '{mk(FUNC_DONE, 0, 0, TMAX), 1'b0, '0};
    dir_table[12] = '{mk(FUNC_DONE, 0, 0, 48'd3000), 1'b0, '0};
    dir_table[13] = '{mk(FUNC_DONE, 0, 0, 48'd3001), 1'b0, '0};
    dir_table[14] = '{mk(FUNC_DONE, 0, 0, 48'd3002), 1'b0, '0};
    dir_table[15] = '{mk(FUNC_DONE, 0, 0, 48'd3003), 1'b0, '0};
    dir_table[16] = '{mk(FUNC_DONE, 0, 0, 48'd3004), 1'b0, '0};
    dir_table[17] = '{mk(FUNC_DONE, 0, 0, 48'd3005), 1'b0, '0};
    dir_table[18] = '{mk(FUNC_DONE, 0, 0, 48'd3006), 1'b0, '0};
    dir_table[19] = '{mk(FUNC_ARRIVE, 16'h8001, 48'h8000_0000_0001, 48'h7FFF_FFFF_FFFF),
                      1'b0, '0};
    dir_table[20] = '{mk(FUNC_DONE, 0, 0, 48'd1), 1'b0, '0};
  end

  int send_gap_pct;

  // Drive one word; hold start until the block takes it. Start stays high
  // after the accepting edge so a following word can go out back to back.
  task automatic send_word(input sps_in_t w, input logic known, input sps_out_t r);
    sps_out_t p;
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = schedule_event(w);
    if (known && p !== r) report_mismatch("directed row model", p, r);
    pending_results.push_back(known ? r : p);
  endtask

  // Random word: mostly small sizes and times near a running clock, some fully random
  sps_time_t sim_now;

  function automatic sps_in_t random_word(input int mode);
    sps_in_t w;
    w.func   = ($urandom_range(99) < 45) ? FUNC_DONE : FUNC_ARRIVE;
    w.job_id = (mode == 0) ? sps_id_t'($urandom_range(15)) : sps_id_t'($urandom);
    if ($urandom_range(9) == 0) begin
      w.job_size     = sps_time_t'({$urandom, $urandom});
      w.current_time = sps_time_t'({$urandom, $urandom});
    end else begin
      sim_now        = sim_now + sps_time_t'($urandom_range(40));
      w.job_size     = sps_time_t'($urandom_range(60));
      w.current_time = ($urandom_range(19) == 0) ? sim_now - sps_time_t'(30) : sim_now;
    end
    return w;
  endfunction

  initial begin
    sps_in_t w;
    n_errors    = 0;
    idle_cycles = 0;
    sim_now     = 48'd5000;
    send_gap_pct = 0;
    m_run_valid = 0; m_run_id = 0; m_run_rem = 0; m_run_start = 0; m_wait_cnt = 0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_word(dir_table[i].w, dir_table[i].known, dir_table[i].r);

    // Fill the queue past full, then drain it
    for (int i = 0; i < QDEPTH + 3; i++)
      send_word(mk(FUNC_ARRIVE, sps_id_t'($urandom), 48'd50 + sps_time_t'(i), sim_now),
                1'b0, '0);
    for (int i = 0; i < QDEPTH + 2; i++)
      send_word(mk(FUNC_DONE, 0, 0, sim_now + sps_time_t'(i)), 1'b0, '0);

    // Random traffic in idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0: send_gap_pct = 0;
        1: send_gap_pct = 66;
        2: send_gap_pct = 31;
        default: send_gap_pct = (i % 100 < 50) ? 0 : 66;
      endcase
      w = random_word(i % 3);
      // bias toward arrivals in the first 80 of every 200 words, to build queue depth
      if (i % 200 < 80 && w.func == FUNC_DONE && $urandom_range(1)) w.func = FUNC_ARRIVE;
      send_word(w, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (QDEPTH + 20) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
